// ----- sv/ata_rd_pkg.sv -----
package ata_rd_pkg;

    // input item kinds, carried in s_tuser
    localparam logic [1:0] ACT_START  = 2'd0;
    localparam logic [1:0] ACT_STATUS = 2'd1;
    localparam logic [1:0] ACT_DATA   = 2'd2;

    localparam logic [7:0]  MAX_CHUNK_SECTORS = 8'd255;
    localparam logic [7:0]  WORD_LAST         = 8'd255;  // 256 words per sector
    localparam logic [27:0] LBA_MASK          = 28'hFFF_FFFF;
    localparam logic [7:0]  CMD_READ          = 8'h20;
    localparam logic [7:0]  DEV_HEAD_BASE     = 8'hE0;
    localparam logic [15:0] IO_BASE_RESET     = 16'h01F0;

    // status bits
    localparam int ST_ERR = 0;
    localparam int ST_DRQ = 3;
    localparam int ST_DF  = 5;
    localparam int ST_BSY = 7;

    // task-file register offsets
    localparam logic [2:0] REG_DATA   = 3'd0;
    localparam logic [2:0] REG_SECCNT = 3'd2;
    localparam logic [2:0] REG_CMD    = 3'd7;

    // configuration register addresses
    localparam logic [2:0] CFG_IO_BASE = 3'd0;

    typedef enum logic [2:0] {
        TAIL_DONE,
        TAIL_ERR,
        TAIL_POLL,
        TAIL_DREAD,
        TAIL_CHUNK
    } tail_t;

    // one queued job for the back end
    typedef struct packed {
        logic        has_word;
        logic [15:0] word;
        tail_t       tail;
        logic [7:0]  size;
        logic [27:0] lba;
        logic        slave;
    } desc_t;

    // one result beat
    typedef struct packed {
        logic        bus_valid;
        logic        bus_write;
        logic [15:0] bus_address;
        logic [7:0]  write_data;
        logic        word_valid;
        logic [15:0] read_word;
        logic        error;
        logic        done_res;
        logic        last;
    } res_t;

endpackage

// ----- sv/ata_rd_front.sv -----
module ata_rd_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [1:0]           action,
    input  logic [27:0]          lba,
    input  logic [15:0]          sector_count,
    input  logic                 slave_drive,
    input  logic [15:0]          reply_data,
    output logic                 push,
    output ata_rd_pkg::desc_t    desc
);
    import ata_rd_pkg::*;

    logic        busy_reg, busy_next;
    logic        want_reg, want_next;
    logic [27:0] lba_reg, lba_next;
    logic [15:0] rem_reg, rem_next;
    logic [7:0]  left_reg, left_next;
    logic [7:0]  wis_reg, wis_next;
    logic        slave_reg, slave_next;
    logic [7:0]  csize_reg, csize_next;

    logic [15:0] chunk_src;
    logic [7:0]  chunk_len;
    logic [7:0]  left_dec;
    logic [27:0] lba_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            want_reg  <= 1'b0;
            lba_reg   <= '0;
            rem_reg   <= '0;
            left_reg  <= '0;
            wis_reg   <= '0;
            slave_reg <= 1'b0;
            csize_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            want_reg  <= want_next;
            lba_reg   <= lba_next;
            rem_reg   <= rem_next;
            left_reg  <= left_next;
            wis_reg   <= wis_next;
            slave_reg <= slave_next;
            csize_reg <= csize_next;
        end
    end

    assign chunk_src = (action == ACT_START) ? sector_count : rem_reg;
    assign chunk_len = (chunk_src > {8'd0, MAX_CHUNK_SECTORS}) ? MAX_CHUNK_SECTORS
                                                               : chunk_src[7:0];
    assign left_dec  = left_reg - 8'd1;
    assign lba_adv   = (lba_reg + {20'd0, csize_reg}) & LBA_MASK;

    always_comb
    begin
        busy_next  = busy_reg;
        want_next  = want_reg;
        lba_next   = lba_reg;
        rem_next   = rem_reg;
        left_next  = left_reg;
        wis_next   = wis_reg;
        slave_next = slave_reg;
        csize_next = csize_reg;
        push       = 1'b0;
        desc       = '{has_word: 1'b0, word: reply_data, tail: TAIL_POLL,
                       size: chunk_len, lba: lba_reg, slave: slave_reg};
        if (accept)
        begin
            case (action)
                ACT_START:
                begin
                    if (!busy_reg)
                    begin
                        lba_next   = lba;
                        rem_next   = sector_count;
                        slave_next = slave_drive;
                        push       = 1'b1;
                        desc.lba   = lba;
                        desc.slave = slave_drive;
                        if (sector_count == 16'd0)
                        begin
                            desc.tail = TAIL_DONE;
                        end
                        else
                        begin
                            busy_next  = 1'b1;
                            csize_next = chunk_len;
                            left_next  = chunk_len;
                            rem_next   = sector_count - {8'd0, chunk_len};
                            wis_next   = '0;
                            want_next  = 1'b0;
                            desc.tail  = TAIL_CHUNK;
                        end
                    end
                end
                ACT_STATUS:
                begin
                    if (busy_reg && !want_reg)
                    begin
                        push = 1'b1;
                        if (reply_data[ST_BSY])
                        begin
                            desc.tail = TAIL_POLL;
                        end
                        else if (reply_data[ST_ERR] || reply_data[ST_DF])
                        begin
                            busy_next = 1'b0;
                            want_next = 1'b0;
                            desc.tail = TAIL_ERR;
                        end
                        else if (reply_data[ST_DRQ])
                        begin
                            want_next = 1'b1;
                            wis_next  = '0;
                            desc.tail = TAIL_DREAD;
                        end
                        else
                        begin
                            desc.tail = TAIL_POLL;
                        end
                    end
                end
                ACT_DATA:
                begin
                    if (busy_reg && want_reg)
                    begin
                        push          = 1'b1;
                        desc.has_word = 1'b1;
                        if (wis_reg != WORD_LAST)
                        begin
                            wis_next  = wis_reg + 8'd1;
                            desc.tail = TAIL_DREAD;
                        end
                        else
                        begin
                            wis_next  = '0;
                            want_next = 1'b0;
                            left_next = left_dec;
                            if (left_dec != 8'd0)
                            begin
                                desc.tail = TAIL_POLL;
                            end
                            else
                            begin
                                lba_next = lba_adv;
                                desc.lba = lba_adv;
                                if (rem_reg != 16'd0)
                                begin
                                    csize_next = chunk_len;
                                    left_next  = chunk_len;
                                    rem_next   = rem_reg - {8'd0, chunk_len};
                                    desc.tail  = TAIL_CHUNK;
                                end
                                else
                                begin
                                    busy_next = 1'b0;
                                    desc.tail = TAIL_DONE;
                                end
                            end
                        end
                    end
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    a_want_busy: assert property (@(posedge clk) disable iff (!rst_n)
        want_reg |-> busy_reg)
        else $error("waiting for data while idle");

    a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (left_reg != 8'd0))
        else $error("busy with an empty chunk");

    a_left_le_size: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (left_reg <= csize_reg))
        else $error("chunk sectors left exceed chunk size");

endmodule

// ----- sv/ata_rd_fifo.sv -----
module ata_rd_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  ata_rd_pkg::desc_t    push_desc,
    input  logic                 pop,
    output ata_rd_pkg::desc_t    head,
    output logic                 empty,
    output logic                 full
);
    import ata_rd_pkg::*;

    desc_t      slot_reg [4];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + {2'd0, push} - {2'd0, pop};
        end
    end

    assign head  = slot_reg[rd_ptr_reg];
    assign empty = (count_reg == 3'd0);
    assign full  = (count_reg == 3'd4);

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("queue underflow");

endmodule

// ----- sv/ata_rd_back.sv -----
module ata_rd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [15:0]          io_base,
    input  ata_rd_pkg::desc_t    head,
    input  logic                 empty,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ata_rd_pkg::res_t     out_res
);
    import ata_rd_pkg::*;

    logic [2:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    res_t       res_reg;
    res_t       beat;
    logic       load;
    logic [2:0] t;
    logic [2:0] off;
    logic       word_beat;

    assign load      = !empty && (!valid_reg || out_ready);
    assign word_beat = head.has_word && (idx_reg == 3'd0);
    assign t         = idx_reg - {2'd0, head.has_word};

    always_comb
    begin
        beat = '0;
        off  = REG_CMD;
        if (word_beat)
        begin
            beat.word_valid = 1'b1;
            beat.read_word  = head.word;
        end
        else
        begin
            case (head.tail)
                TAIL_DONE:
                begin
                    beat.done_res = 1'b1;
                    beat.last     = 1'b1;
                end
                TAIL_ERR:
                begin
                    beat.error    = 1'b1;
                    beat.done_res = 1'b1;
                    beat.last     = 1'b1;
                end
                TAIL_POLL:
                begin
                    beat.bus_valid = 1'b1;
                    off            = REG_CMD;
                    beat.last      = 1'b1;
                end
                TAIL_DREAD:
                begin
                    beat.bus_valid = 1'b1;
                    off            = REG_DATA;
                    beat.last      = 1'b1;
                end
                TAIL_CHUNK:
                begin
                    // six task-file writes, then the first status read
                    beat.bus_valid = 1'b1;
                    if (t == 3'd6)
                    begin
                        off       = REG_CMD;
                        beat.last = 1'b1;
                    end
                    else
                    begin
                        off            = REG_SECCNT + t;
                        beat.bus_write = 1'b1;
                    end
                    case (t)
                        3'd0:    beat.write_data = head.size;
                        3'd1:    beat.write_data = head.lba[7:0];
                        3'd2:    beat.write_data = head.lba[15:8];
                        3'd3:    beat.write_data = head.lba[23:16];
                        3'd4:    beat.write_data = DEV_HEAD_BASE | {3'd0, head.slave, head.lba[27:24]};
                        3'd5:    beat.write_data = CMD_READ;
                        default: beat.write_data = 8'd0;
                    endcase
                end
                default:
                begin
                    beat.last = 1'b1;
                end
            endcase
        end
        beat.bus_address = beat.bus_valid ? (io_base + {13'd0, off}) : 16'd0;
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        pop        = 1'b0;
        if (load)
        begin
            valid_next = 1'b1;
            if (beat.last)
            begin
                idx_next = '0;
                pop      = 1'b1;
            end
            else
            begin
                idx_next = idx_reg + 3'd1;
            end
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= beat;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= 3'd7)
        else $error("beat index out of range");

    a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (valid_reg && res_reg.last))
        else $error("job retired without a last beat");

endmodule

// ----- sv/ata_pio_lba28_read_sequencer.sv -----
// ATA PIO LBA28 read sequencer, host side.
// Slave stream (s_*): one beat per event. s_tuser selects the kind: start a
// read request, a status byte came back, or a data word came back.
// Master stream (m_*): result beats. Each carries a task-file bus access, a
// delivered data word, or a done/error flag; m_tlast marks the last beat
// caused by one input beat. A start with a non-zero count emits seven beats (six
// task-file writes and a status read); a data word at a chunk boundary emits eight.
// APB port: one register, io_base at address 0 (reset 0x1F0); write it idle.
// The front end takes one input beat per cycle while the queue is not full and
// queues a job (four deep); the back end expands jobs into result beats, one
// per cycle while m_tready allows, through an output register. The first
// result beat passes through the queue slot, then the output register. Sustained
// rate is set by the back end's output, up to eight beats per input beat. When
// m_tready is low the output register holds; the queue fills and then s_tready drops.
// Reset clears the request state and queue; no clearing pass is needed.
module ata_pio_lba28_read_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // lba[27:0], sector_count[43:28], slave_drive[44],
                                   // reply_data[60:45], zero pad
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // bus_address[15:0], write_data[23:16],
                                   // read_word[39:24], error[40], done_res[41], zero pad
    output logic [2:0]  m_tuser,   // bus_valid[0], bus_write[1], word_valid[2]
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ata_rd_pkg::*;

    logic [15:0] io_base_reg;
    logic        accept;
    logic        push;
    desc_t       push_desc;
    desc_t       head;
    logic        empty;
    logic        full;
    logic        pop;
    res_t        res;

    assign pready = 1'b1;
    assign prdata = (paddr == CFG_IO_BASE) ? {16'd0, io_base_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            io_base_reg <= IO_BASE_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr == CFG_IO_BASE))
        begin
            io_base_reg <= pwdata[15:0];
        end
    end

    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    ata_rd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .action       (s_tuser),
        .lba          (s_tdata[27:0]),
        .sector_count (s_tdata[43:28]),
        .slave_drive  (s_tdata[44]),
        .reply_data   (s_tdata[60:45]),
        .push         (push),
        .desc         (push_desc)
    );

    ata_rd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    ata_rd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .io_base   (io_base_reg),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {6'd0, res.done_res, res.error, res.read_word, res.write_data,
                      res.bus_address};
    assign m_tuser = {res.word_valid, res.bus_write, res.bus_valid};
    assign m_tlast = res.last;

endmodule

// ----- sim/ata_pio_lba28_read_checker.sv -----
`timescale 1ns / 1ps

module ata_pio_lba28_read_checker
    import ata_rd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,   // lba[27:0], sector_count[43:28], slave_drive[44],
                                   // reply_data[60:45], zero pad
    input  logic [1:0]  s_tuser,   // action[1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,   // bus_address[15:0], write_data[23:16],
                                   // read_word[39:24], error[40], done_res[41], zero pad
    input  logic [2:0]  m_tuser,   // bus_valid[0], bus_write[1], word_valid[2]
    input  logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending
);

    localparam logic [2:0] REG_LBA_LO   = 3'd3;
    localparam logic [2:0] REG_LBA_MID  = 3'd4;
    localparam logic [2:0] REG_LBA_HI   = 3'd5;
    localparam logic [2:0] REG_DEV_HEAD = 3'd6;

    logic [15:0] io_base;
    logic        busy;
    logic [27:0] cur_lba;
    logic [15:0] sectors_left;
    logic [7:0]  chunk_left;
    logic [7:0]  chunk_len;
    logic [7:0]  word_idx;
    logic        slave_sel;
    logic        want_data;

    res_t        due_beats[$];
    res_t        burst[8];
    int          n_burst;
    res_t        want;
    res_t        got;

    function automatic res_t mk(input logic bv, input logic bw, input logic [2:0] off,
                                input logic [7:0] wd, input logic wv, input logic [15:0] word,
                                input logic err, input logic done);
        res_t r;
        r.bus_valid   = bv;
        r.bus_write   = bw;
        r.bus_address = bv ? io_base + 16'(off) : 16'h0;
        r.write_data  = wd;
        r.word_valid  = wv;
        r.read_word   = word;
        r.error       = err;
        r.done_res    = done;
        r.last        = 1'b0;
        return r;
    endfunction

    task automatic add(input res_t r);
        burst[n_burst] = r;
        n_burst++;
    endtask

    // task-file writes for the next command, then the first status read
    task automatic open_chunk();
        logic [7:0] len;
        len = (sectors_left > 16'(MAX_CHUNK_SECTORS)) ? MAX_CHUNK_SECTORS : sectors_left[7:0];
        chunk_len    = len;
        chunk_left   = len;
        sectors_left = sectors_left - 16'(len);
        word_idx     = 8'h0;
        want_data    = 1'b0;
        add(mk(1'b1, 1'b1, REG_SECCNT, len, 1'b0, 16'h0, 1'b0, 1'b0));
        add(mk(1'b1, 1'b1, REG_LBA_LO, cur_lba[7:0], 1'b0, 16'h0, 1'b0, 1'b0));
        add(mk(1'b1, 1'b1, REG_LBA_MID, cur_lba[15:8], 1'b0, 16'h0, 1'b0, 1'b0));
        add(mk(1'b1, 1'b1, REG_LBA_HI, cur_lba[23:16], 1'b0, 16'h0, 1'b0, 1'b0));
        add(mk(1'b1, 1'b1, REG_DEV_HEAD, DEV_HEAD_BASE | {3'b000, slave_sel, cur_lba[27:24]},
               1'b0, 16'h0, 1'b0, 1'b0));
        add(mk(1'b1, 1'b1, REG_CMD, CMD_READ, 1'b0, 16'h0, 1'b0, 1'b0));
        add(mk(1'b1, 1'b0, REG_CMD, 8'h0, 1'b0, 16'h0, 1'b0, 1'b0));
    endtask

    task automatic step_read_engine(input logic [1:0] act, input logic [63:0] data);
        logic [15:0] reply;
        reply   = data[60:45];
        n_burst = 0;
        case (act)
            ACT_START:
                if (!busy) begin
                    cur_lba      = data[27:0] & LBA_MASK;
                    sectors_left = data[43:28];
                    slave_sel    = data[44];
                    if (sectors_left == 16'h0)
                        add(mk(1'b0, 1'b0, 3'd0, 8'h0, 1'b0, 16'h0, 1'b0, 1'b1));
                    else
                    begin
                        busy = 1'b1;
                        open_chunk();
                    end
                end
            ACT_STATUS:
                if (busy && !want_data) begin
                    // BSY hides every other bit
                    if (reply[ST_BSY])
                        add(mk(1'b1, 1'b0, REG_CMD, 8'h0, 1'b0, 16'h0, 1'b0, 1'b0));
                    else if (reply[ST_ERR] || reply[ST_DF])
                    begin
                        busy      = 1'b0;
                        want_data = 1'b0;
                        add(mk(1'b0, 1'b0, 3'd0, 8'h0, 1'b0, 16'h0, 1'b1, 1'b1));
                    end
                    else if (reply[ST_DRQ])
                    begin
                        want_data = 1'b1;
                        word_idx  = 8'h0;
                        add(mk(1'b1, 1'b0, REG_DATA, 8'h0, 1'b0, 16'h0, 1'b0, 1'b0));
                    end
                    else
                        add(mk(1'b1, 1'b0, REG_CMD, 8'h0, 1'b0, 16'h0, 1'b0, 1'b0));
                end
            ACT_DATA:
                if (busy && want_data) begin
                    add(mk(1'b0, 1'b0, 3'd0, 8'h0, 1'b1, reply, 1'b0, 1'b0));
                    if (word_idx != WORD_LAST) begin
                        word_idx = word_idx + 8'd1;
                        add(mk(1'b1, 1'b0, REG_DATA, 8'h0, 1'b0, 16'h0, 1'b0, 1'b0));
                    end
                    else
                    begin
                        word_idx   = 8'h0;
                        want_data  = 1'b0;
                        chunk_left = chunk_left - 8'd1;
                        if (chunk_left != 8'h0)
                            add(mk(1'b1, 1'b0, REG_CMD, 8'h0, 1'b0, 16'h0, 1'b0, 1'b0));
                        else
                        begin
                            cur_lba = (cur_lba + 28'(chunk_len)) & LBA_MASK;
                            if (sectors_left != 16'h0)
                                open_chunk();
                            else
                            begin
                                busy = 1'b0;
                                add(mk(1'b0, 1'b0, 3'd0, 8'h0, 1'b0, 16'h0, 1'b0, 1'b1));
                            end
                        end
                    end
                end
            default: ;
        endcase
        if (n_burst > 0)
            burst[n_burst - 1].last = 1'b1;
        for (int i = 0; i < n_burst; i++)
            due_beats.push_back(burst[i]);
    endtask

    task automatic cmp(input string fname, input int exp_v, input int got_v);
        if (exp_v != got_v) begin
            $display("%0t: %s expected %h actual %h", $time, fname, exp_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            io_base      = IO_BASE_RESET;
            busy         = 1'b0;
            cur_lba      = 28'h0;
            sectors_left = 16'h0;
            chunk_left   = 8'h0;
            chunk_len    = 8'h0;
            word_idx     = 8'h0;
            slave_sel    = 1'b0;
            want_data    = 1'b0;
            due_beats.delete();
            fail_count   = 0;
            pending     <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == CFG_IO_BASE)
                io_base = pwdata[15:0];

            if (m_tvalid && m_tready) begin
                got.bus_address = m_tdata[15:0];
                got.write_data  = m_tdata[23:16];
                got.read_word   = m_tdata[39:24];
                got.error       = m_tdata[40];
                got.done_res    = m_tdata[41];
                got.bus_valid   = m_tuser[0];
                got.bus_write   = m_tuser[1];
                got.word_valid  = m_tuser[2];
                got.last        = m_tlast;
                if (due_beats.size() == 0) begin
                    $display("%0t: unexpected result beat expected none actual %h %h %b",
                             $time, m_tdata, m_tuser, m_tlast);
                    fail_count++;
                end
                else
                begin
                    want = due_beats.pop_front();
                    cmp("bus_valid", int'(want.bus_valid), int'(got.bus_valid));
                    cmp("bus_write", int'(want.bus_write), int'(got.bus_write));
                    cmp("bus_address", int'(want.bus_address), int'(got.bus_address));
                    cmp("write_data", int'(want.write_data), int'(got.write_data));
                    cmp("word_valid", int'(want.word_valid), int'(got.word_valid));
                    cmp("read_word", int'(want.read_word), int'(got.read_word));
                    cmp("error", int'(want.error), int'(got.error));
                    cmp("done_res", int'(want.done_res), int'(got.done_res));
                    cmp("last", int'(want.last), int'(got.last));
                end
            end

            if (s_tvalid && s_tready)
                step_read_engine(s_tuser, s_tdata);

            pending <= due_beats.size();
        end
    end

endmodule

// ----- sim/ata_pio_lba28_read_sequencer_tb.sv -----
`timescale 1ns / 1ps

module ata_pio_lba28_read_sequencer_tb;
    import ata_rd_pkg::*;

    localparam logic [1:0]  ACT_NONE     = 2'd3;
    localparam int          CYCLE_LIMIT  = 200_000;
    localparam int          DRAIN_CYCLES = 24;
    localparam int          RANDOM_ITEMS = 135;
    localparam int          SECTOR_ITEMS = 270;  // one sector read with its polling
    localparam logic [63:0] PAD_MASK     = 64'h1FFF_FFFF_FFFF_FFFF;
    localparam logic [7:0]  ST_ERR_M     = 8'(1) << ST_ERR;
    localparam logic [7:0]  ST_DRQ_M     = 8'(1) << ST_DRQ;
    localparam logic [7:0]  ST_DF_M      = 8'(1) << ST_DF;
    localparam logic [7:0]  ST_BSY_M     = 8'(1) << ST_BSY;

    typedef enum int {SK_BUSY, SK_SETTLE, SK_DRQ, SK_FAULT} status_kind_t;
    typedef enum int {CTX_IDLE, CTX_WAIT_ST, CTX_WAIT_DATA} ctx_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = 64'h0;
    logic [1:0]  s_tuser  = ACT_NONE;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [47:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = 3'd0;
    logic [31:0] pwdata   = 32'h0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;

    bit          idle_on = 1'b1;
    int          stall_cnt = 0;
    int          real_items = 0;
    int          goal;
    logic [15:0] base;

    ata_pio_lba28_read_sequencer u_top (.*);

    ata_pio_lba28_read_checker u_chk (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver back-pressure in random bursts
    always @(posedge clk)
    begin
        if (stall_cnt != 0) begin
            stall_cnt <= stall_cnt - 1;
            m_tready  <= (stall_cnt == 1);
        end
        else if (idle_on && $urandom_range(0, 9) == 0)
        begin
            stall_cnt <= $urandom_range(1, 13);
            m_tready  <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [63:0] pack_in(input logic [27:0] lba, input logic [15:0] cnt,
                                            input logic slave, input logic [15:0] reply);
        return {3'b000, reply, slave, cnt, lba};
    endfunction

    function automatic logic [7:0] status_byte(input status_kind_t k);
        logic [7:0] st;
        st = 8'($urandom);
        case (k)
            SK_BUSY:   st[ST_BSY] = 1'b1;
            SK_SETTLE: st = st & ~(ST_BSY_M | ST_ERR_M | ST_DF_M | ST_DRQ_M);
            SK_DRQ:    st = (st & ~(ST_BSY_M | ST_ERR_M | ST_DF_M)) | ST_DRQ_M;
            default:
            begin
                st[ST_BSY] = 1'b0;
                case ($urandom_range(0, 2))
                    0:       st[ST_ERR] = 1'b1;
                    1:       st[ST_DF] = 1'b1;
                    default: st = st | ST_ERR_M | ST_DF_M;
                endcase
            end
        endcase
        return st;
    endfunction

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_beat(input logic [1:0] kind, input logic [63:0] payload);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= payload;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic send_start(input logic [27:0] lba, input logic [15:0] cnt,
                              input logic slave);
        send_beat(ACT_START, pack_in(lba, cnt, slave, 16'($urandom)));
        real_items++;
    endtask

    task automatic send_status(input logic [7:0] st);
        send_beat(ACT_STATUS, pack_in(28'($urandom), 16'($urandom), 1'($urandom),
                                      {8'($urandom), st}));
        real_items++;
    endtask

    task automatic send_word(input logic [15:0] w);
        send_beat(ACT_DATA, pack_in(28'($urandom), 16'($urandom), 1'($urandom), w));
        real_items++;
    endtask

    // only kinds the block drops in the given state
    task automatic maybe_noise(input ctx_t ctx);
        logic [1:0] kind;
        if ($urandom_range(0, 19) == 0) begin
            case ($urandom_range(0, 2))
                0:       kind = (ctx == CTX_IDLE) ? ACT_STATUS : ACT_START;
                1:       kind = (ctx == CTX_WAIT_DATA) ? ACT_STATUS : ACT_DATA;
                default: kind = ACT_NONE;
            endcase
            send_beat(kind, {$urandom, $urandom} & PAD_MASK);
        end
    endtask

    task automatic read_sector();
        repeat ($urandom_range(0, 3))
            send_status(status_byte($urandom_range(0, 1) ? SK_BUSY : SK_SETTLE));
        maybe_noise(CTX_WAIT_ST);
        send_status(status_byte(SK_DRQ));
        for (int w = 0; w < 256; w++) begin
            maybe_noise(CTX_WAIT_DATA);
            send_word(rand_word());
        end
    endtask

    // good = sectors read cleanly; if good is below the count, a fault then ends the request
    task automatic run_request(input logic [27:0] lba, input logic [15:0] cnt,
                               input logic slave, input int good);
        send_start(lba, cnt, slave);
        if (cnt != 16'h0) begin
            for (int s = 0; s < good; s++)
                read_sector();
            if (good < int'(cnt)) begin
                repeat ($urandom_range(0, 2)) send_status(status_byte(SK_BUSY));
                maybe_noise(CTX_WAIT_ST);
                send_status(status_byte(SK_FAULT));
            end
        end
        maybe_noise(CTX_IDLE);
    endtask

    task automatic random_request();
        int          pick;
        logic [15:0] cnt;
        int          good;
        idle_on = ($urandom_range(0, 3) != 0);
        pick    = $urandom_range(0, 99);
        cnt     = 16'($urandom);
        good    = 0;
        if (pick < 15)
            cnt = 16'h0;
        else if (pick < 55)
        begin
            if (cnt == 16'h0)
                cnt = 16'h1;
        end
        else if (pick < 70)
        begin
            if (cnt < 16'd2)
                cnt = 16'd2;
            good = 1;
        end
        else
        begin
            cnt  = 16'd1;
            good = 1;
        end
        // a sector read only where the phase budget still holds one
        if (good != 0 && (goal - real_items) < SECTOR_ITEMS)
            good = 0;
        maybe_noise(CTX_IDLE);
        run_request(28'($urandom), cnt, 1'($urandom), good);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: dropped beats, zero length, status corner cases, abort flavors
        send_beat(ACT_DATA, pack_in(28'h0, 16'h0, 1'b0, 16'hFFFF));
        send_beat(ACT_STATUS, pack_in(LBA_MASK, 16'hFFFF, 1'b1, {8'hFF, ST_DRQ_M}));
        send_beat(ACT_NONE, pack_in(LBA_MASK, 16'hFFFF, 1'b1, 16'hFFFF));
        send_start(LBA_MASK, 16'h0000, 1'b1);
        send_start(LBA_MASK, 16'hFFFF, 1'b1);
        send_beat(ACT_START, pack_in(28'h0, 16'h1, 1'b0, 16'h0));
        send_beat(ACT_DATA, pack_in(28'h0, 16'h0, 1'b0, 16'hA5A5));
        send_status(8'hFF);
        send_status(8'h00);
        send_status(ST_ERR_M | ST_DRQ_M);
        send_start(28'h0, 16'h0001, 1'b0);
        send_status(ST_DF_M);
        send_start(28'h0000001, 16'd255, 1'b0);
        send_status(ST_BSY_M | ST_ERR_M | ST_DF_M);
        send_status(ST_ERR_M);
        send_beat(ACT_NONE, pack_in(28'h0, 16'h0, 1'b0, 16'h0));
        drain();

        // random requests under three base addresses
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0:       base = 16'h0000;
                1:       base = 16'hFFFF;
                default: base = 16'($urandom);
            endcase
            apb_write(CFG_IO_BASE, {16'h0, base});
            goal = real_items + RANDOM_ITEMS / 3;
            while (real_items < goal)
                random_request();
            drain();
        end

        // one full sector read to completion near the top of the LBA range, no idling
        idle_on = 1'b0;
        apb_write(CFG_IO_BASE, {16'h0, 16'($urandom)});
        run_request(28'h0FFFFF80 | 28'($urandom_range(0, 127)), 16'd1, 1'($urandom), 1);
        drain();

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
